@@ rtl/core/abt_pkg.sv @@
package abt_pkg;

    // Tree geometry
    localparam int TREE_SIZE = 15;
    localparam int IDX_W     = (TREE_SIZE > 1) ? $clog2(TREE_SIZE) : 1;
    localparam int FILL_W    = $clog2(TREE_SIZE + 1);
    // slot numbers reach 2*(TREE_SIZE-1)+2 while walking off the leaves
    localparam int SLOT_W    = $clog2(2 * TREE_SIZE + 1);

    // Field widths
    localparam int KEY_W  = 8;
    localparam int POS_W  = 4;
    localparam int STAT_W = 2;
    localparam int REQ_W  = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LIST   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    // Write request into the key store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] data;
    } abt_wr_t;

endpackage

@@ rtl/core/array_binary_tree_engine.sv @@
// Array binary tree engine: heap-indexed key store walked by one slot pointer.
// Insert: result strobe the cycle after start, busy never rises, one item a cycle.
// Delete: one slot per cycle; busy while every slot is swept, result strobe once busy falls.
// List/find: busy while walking the keys reachable from the root (find stops at its match),
// final item in the first cycle that busy is low; start is taken whenever busy is low.
// Results are single-cycle strobes; the receiver cannot stall them. Reset (rst_n, async,
// active low) empties every slot and zeroes the fill index.
module array_binary_tree_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [abt_pkg::REQ_W-1:0]   req_type,
    input  logic [abt_pkg::KEY_W-1:0]   key,
    output logic                        strobe,
    output logic [abt_pkg::STAT_W-1:0]  status,
    output logic [abt_pkg::KEY_W-1:0]   listed_key,
    output logic [abt_pkg::POS_W-1:0]   position,
    output logic                        last
);
    import abt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEL  = 4'b0010,
        S_DOWN = 4'b0100,
        S_RET  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [IDX_W-1:0]    del_reg, del_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [POS_W-1:0]    count_reg, count_next;
    logic                find_reg, find_next;
    logic                hit_reg, hit_next;

    logic                strobe_reg, strobe_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [KEY_W-1:0]    lkey_reg, lkey_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                last_reg, last_next;

    abt_wr_t             wr;
    logic [SLOT_W-1:0]   rd_addr;
    logic [KEY_W-1:0]    rd_data;
    logic                rd_present;
    logic [SLOT_W-1:0]   parent;
    logic [POS_W-1:0]    count_inc;
    logic                match;

    abt_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .rd_present (rd_present)
    );

    // Shared address and compare path
    assign parent    = (slot_reg - SLOT_W'(1)) >> 1;
    assign match     = (rd_data == key_reg);
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + POS_W'(1);

    always_comb
    begin
        case (state_reg)
            S_DEL:   rd_addr = SLOT_W'(del_reg);
            S_RET:   rd_addr = parent;
            default: rd_addr = slot_reg;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        del_next    = del_reg;
        fill_next   = fill_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        find_next   = find_reg;
        hit_next    = hit_reg;
        strobe_next = 1'b0;
        status_next = ST_OK;
        lkey_next   = '0;
        pos_next    = '0;
        last_next   = 1'b0;
        wr.en       = 1'b0;
        wr.addr     = fill_reg[IDX_W-1:0];
        wr.data     = key;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next   = key;
                    slot_next  = '0;
                    del_next   = '0;
                    count_next = '0;
                    hit_next   = 1'b0;
                    find_next  = (req_type == REQ_FIND);
                    case (req_type)
                        REQ_INSERT:
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                            if (fill_reg >= FILL_W'(TREE_SIZE))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr.en     = 1'b1;
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        REQ_DELETE: state_next = S_DEL;
                        default:    state_next = S_DOWN;
                    endcase
                end
            end

            // Delete: sweep every slot, clear the matching ones
            S_DEL:
            begin
                wr.addr = del_reg;
                wr.data = '0;
                if (match && key_reg != '0)
                begin
                    wr.en    = 1'b1;
                    hit_next = 1'b1;
                end
                del_next = del_reg + IDX_W'(1);
                if (del_reg == IDX_W'(TREE_SIZE - 1))
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    status_next = (hit_reg || (match && key_reg != '0)) ? ST_OK : ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
            end

            // Descend: go left from a present slot, climb back from an empty one
            S_DOWN:
            begin
                if (rd_present)
                begin
                    slot_next = (slot_reg << 1) + SLOT_W'(1);
                end
                else if (slot_reg == '0)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    status_next = find_reg ? ST_NOT_FOUND : ST_EMPTY;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_RET;
                end
            end

            // Return to the parent of slot_reg
            S_RET:
            begin
                if (slot_reg[0])
                begin
                    // back from the left child: inorder visit, then go right
                    if (find_reg)
                    begin
                        count_next = count_inc;
                    end
                    if (find_reg && match)
                    begin
                        strobe_next = 1'b1;
                        last_next   = 1'b1;
                        pos_next    = count_inc;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        slot_next  = (parent << 1) + SLOT_W'(2);
                        state_next = S_DOWN;
                    end
                end
                else
                begin
                    // back from the right child: postorder visit, climb on
                    if (!find_reg)
                    begin
                        strobe_next = 1'b1;
                        lkey_next   = rd_data;
                        last_next   = (parent == '0);
                    end
                    else if (parent == '0)
                    begin
                        strobe_next = 1'b1;
                        last_next   = 1'b1;
                        status_next = ST_NOT_FOUND;
                    end
                    slot_next = parent;
                    if (parent == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            strobe_reg <= strobe_next;
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        del_reg    <= del_next;
        key_reg    <= key_next;
        count_reg  <= count_next;
        find_reg   <= find_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        lkey_reg   <= lkey_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign strobe     = strobe_reg;
    assign status     = status_reg;
    assign listed_key = lkey_reg;
    assign position   = pos_reg;
    assign last       = last_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(TREE_SIZE))
        else $error("fill index beyond store");

    a_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |-> (status_reg == ST_OK && lkey_reg != '0))
        else $error("non-final item is not a listed key");

    a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && pos_reg != '0) |-> (status_reg == ST_OK && lkey_reg == '0))
        else $error("position on a non-find item");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && state_next == S_IDLE) |=> (strobe_reg && last_reg))
        else $error("request finished without a final item");

endmodule

@@ rtl/core/abt_store.sv @@
module abt_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  abt_pkg::abt_wr_t            wr,
    input  logic [abt_pkg::SLOT_W-1:0]  rd_addr,
    output logic [abt_pkg::KEY_W-1:0]   rd_data,
    output logic                        rd_present
);
    import abt_pkg::*;

    logic [KEY_W-1:0] mem_reg [TREE_SIZE];
    logic             in_range;

    // Key slots, cleared to empty on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TREE_SIZE; i++)
            begin
                mem_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    // Slots past the end of the store read as empty
    assign in_range   = rd_addr < SLOT_W'(TREE_SIZE);
    assign rd_data    = in_range ? mem_reg[rd_addr[IDX_W-1:0]] : '0;
    assign rd_present = (rd_data != '0);

endmodule
